### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, ignored while i_rst_n is low.
`define SBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define SBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### hdl/sbs_pkg.sv
package sbs_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 16;

    // Register field widths
    localparam int AXIS_COUNT_BITS = 2;
    localparam int EXT_BITS        = 16;
    localparam int BLK_BITS        = 8;

    // Width of one result item on the output stream
    localparam int KEPT_BITS       = 32;

    // Axes the register map can describe
    localparam int REG_AXES        = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AXIS_COUNT = 3'd0,
        REG_EXTENT_A   = 3'd1,
        REG_EXTENT_B   = 3'd2,
        REG_EXTENT_C   = 3'd3,
        REG_BLOCK_SIZE = 3'd4,
        REG_STRIDE     = 3'd5
    } t_reg_index;

endpackage

### hdl/strided_block_sampler_core.sv
// Strided block sampler.
// Input stream (s_axis_*): one array element per transaction, raster order with the
// fastest axis last; tuser marks the first element of a new array and clears all
// position counters before that element is judged.
// Output stream (m_axis_*): the elements that sit in a kept block, in arrival order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 axis count, 1..3 extents slowest to fastest, 4 block size, 5 stride).
// Write only while the block is idle; counters are left as they are.
// A kept element is registered in the output register (skid register on a stall).
// Throughput: one element per cycle while s_axis_tready is high; the keep test and the
// axis counter carry chain are a single combinational pass off the position registers.
// Stall: a two-entry output queue (output register plus skid register) holds one
// more kept element after the receiver stops; dropped elements keep flowing, and
// s_axis_tready drops only while the skid register is full.
// Reset (synchronous, active low): registers go to 1, counters to the origin, queue
// empties. The block accepts elements as soon as reset is released.
`include "assert_macros.svh"

module strided_block_sampler_core
    import sbs_pkg::*;
#(
    parameter int MAX_AXES   = 3,
    parameter int COORD_BITS = 16,
    parameter int DATA_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]            i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]             i_cfg_data,
    // Element input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((DATA_BITS+7)/8)*8-1:0]       s_axis_tdata,  // [DATA_BITS-1:0] value
    input  logic                                 s_axis_tuser,  // [0] restart
    // Kept element output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [KEPT_BITS-1:0]                 m_axis_tdata   // [31:0] kept_value
);

    localparam int CMP_BITS = ((COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS) + 1;
    localparam logic [AXIS_COUNT_BITS-1:0] MAX_AXES_C = AXIS_COUNT_BITS'(MAX_AXES);

    // Configuration registers
    logic [AXIS_COUNT_BITS-1:0] r_axis_count;
    logic [EXT_BITS-1:0]        r_extent [REG_AXES];
    logic [BLK_BITS-1:0]        r_block_size;
    logic [BLK_BITS-1:0]        r_stride;

    // Per-axis position state, slowest axis first
    logic [COORD_BITS-1:0]      r_coord [MAX_AXES];
    logic [BLK_BITS-1:0]        r_off   [MAX_AXES];
    logic [BLK_BITS-1:0]        r_phase [MAX_AXES];
    logic [COORD_BITS-1:0]      n_coord [MAX_AXES];
    logic [BLK_BITS-1:0]        n_off   [MAX_AXES];
    logic [BLK_BITS-1:0]        n_phase [MAX_AXES];

    // Output queue
    logic                       r_out_valid;
    logic [KEPT_BITS-1:0]       r_out_data;
    logic                       r_skid_valid;
    logic [KEPT_BITS-1:0]       r_skid_data;

    logic                       s_fire;
    logic                       m_fire;
    logic                       w_restart;
    logic [AXIS_COUNT_BITS-1:0] w_axes;
    logic [BLK_BITS-1:0]        w_bs;
    logic [BLK_BITS-1:0]        w_st;
    logic [MAX_AXES-1:0]        w_en;
    logic [MAX_AXES-1:0]        w_ok;
    logic [MAX_AXES-1:0]        w_wrap;
    logic [MAX_AXES:0]          w_carry;
    logic                       w_keep;
    logic                       w_push;
    logic [KEPT_BITS-1:0]       w_value;

    assign s_axis_tready = !r_skid_valid;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_restart     = s_axis_tuser;
    assign w_value       = KEPT_BITS'(s_axis_tdata[DATA_BITS-1:0]);

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_count <= AXIS_COUNT_BITS'(1);
            r_extent[0]  <= EXT_BITS'(1);
            r_extent[1]  <= EXT_BITS'(1);
            r_extent[2]  <= EXT_BITS'(1);
            r_block_size <= BLK_BITS'(1);
            r_stride     <= BLK_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_AXIS_COUNT: r_axis_count <= i_cfg_data[AXIS_COUNT_BITS-1:0];
                REG_EXTENT_A:   r_extent[0]  <= i_cfg_data[EXT_BITS-1:0];
                REG_EXTENT_B:   r_extent[1]  <= i_cfg_data[EXT_BITS-1:0];
                REG_EXTENT_C:   r_extent[2]  <= i_cfg_data[EXT_BITS-1:0];
                REG_BLOCK_SIZE: r_block_size <= i_cfg_data[BLK_BITS-1:0];
                REG_STRIDE:     r_stride     <= i_cfg_data[BLK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Zero block size, stride or axis count behave as one; count capped at MAX_AXES
    always_comb begin
        w_bs = (r_block_size == '0) ? BLK_BITS'(1) : r_block_size;
        w_st = (r_stride == '0) ? BLK_BITS'(1) : r_stride;
        if (r_axis_count == '0) begin
            w_axes = AXIS_COUNT_BITS'(1);
        end else if (r_axis_count > MAX_AXES_C) begin
            w_axes = MAX_AXES_C;
        end else begin
            w_axes = r_axis_count;
        end
    end

    // Carry enters at the fastest axis and ripples toward the slowest
    assign w_carry[MAX_AXES] = 1'b1;

    for (genvar d = 0; d < MAX_AXES; d++) begin : g_axis
        logic [COORD_BITS-1:0] e_coord;
        logic [BLK_BITS-1:0]   e_off;
        logic [BLK_BITS-1:0]   e_phase;
        logic [COORD_BITS-1:0] c_inc;
        logic [BLK_BITS-1:0]   off_inc;
        logic [BLK_BITS-1:0]   ph_inc;
        logic                  adv;

        // Restart moves this element to the origin before it is judged
        assign e_coord = w_restart ? '0 : r_coord[d];
        assign e_off   = w_restart ? '0 : r_off[d];
        assign e_phase = w_restart ? '0 : r_phase[d];

        assign w_en[d] = AXIS_COUNT_BITS'(d) < w_axes;

        // Kept block: phase zero and block end (start + bs) within the extent
        assign w_ok[d] = (e_phase == '0) &&
                         (CMP_BITS'(e_coord) + CMP_BITS'(w_bs) <=
                          CMP_BITS'(r_extent[d]) + CMP_BITS'(e_off));

        assign w_wrap[d] = (e_coord == '1) ||
                           (CMP_BITS'(e_coord) + CMP_BITS'(1) >= CMP_BITS'(r_extent[d]));

        assign adv        = w_en[d] && w_carry[d+1];
        assign w_carry[d] = w_en[d] ? (w_carry[d+1] && w_wrap[d]) : w_carry[d+1];

        assign c_inc   = e_coord + COORD_BITS'(1);
        assign off_inc = e_off + BLK_BITS'(1);
        assign ph_inc  = e_phase + BLK_BITS'(1);

        // Next position of this axis
        always_comb begin
            n_coord[d] = e_coord;
            n_off[d]   = e_off;
            n_phase[d] = e_phase;
            if (adv) begin
                if (w_wrap[d]) begin
                    n_coord[d] = '0;
                    n_off[d]   = '0;
                    n_phase[d] = '0;
                end else begin
                    n_coord[d] = c_inc;
                    if (off_inc >= w_bs) begin
                        n_off[d]   = '0;
                        n_phase[d] = (ph_inc >= w_st) ? '0 : ph_inc;
                    end else begin
                        n_off[d]   = off_inc;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coord[d] <= '0;
                r_off[d]   <= '0;
                r_phase[d] <= '0;
            end else if (s_fire) begin
                r_coord[d] <= n_coord[d];
                r_off[d]   <= n_off[d];
                r_phase[d] <= n_phase[d];
            end
        end
    end

    assign w_keep = &(~w_en | w_ok);
    assign w_push = s_fire && w_keep;

    // Output register with skid slot behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_fire) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_value;
        end
        if (r_out_valid && !m_fire && w_push) begin
            r_skid_data <= w_value;
        end
    end

    // Checks
    `SBS_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid,
        "skid entry held while output register empty")
    `SBS_ASSERT(a_stalled_push_skids,
        (w_push && r_out_valid && !m_axis_tready) |=> r_skid_valid,
        "kept element lost while output stalled")
    `SBS_ASSERT(a_offset_within_coord,
        CMP_BITS'(r_off[0]) <= CMP_BITS'(r_coord[0]),
        "block offset ahead of coordinate on slowest axis")
    `SBS_ASSERT(a_state_holds_idle, !s_fire |=> $stable(r_coord[0]),
        "position moved without an input transaction")

endmodule
